// ----- design/mexp_pkg.sv -----
// Shared constants, register indexes and sequencer states for the modular exponentiation block.
package mexp_pkg;

  // Default parameter values.
  localparam int MOD_BITS_DEF = 31;
  localparam int EXP_BITS_DEF = 32;

  // Fixed field widths of the ports.
  localparam int DATA_BITS   = 31;
  localparam int EXP_IN_BITS = 32;
  localparam int WIDE_BITS   = 64;

  // Configuration port widths.
  localparam int APB_DATA_BITS = 32;
  localparam int APB_ADDR_BITS = 3;

  // Modulus after reset: the prime 1e9+7.
  localparam logic [DATA_BITS-1:0] MODULUS_RESET = 31'd1000000007;

  // Register index, taken from the word address.
  typedef enum logic [0:0] {
    REG_MODULUS = 1'b0
  } reg_idx_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_DISPATCH,
    ST_MUL_ACC,
    ST_MUL_SQ,
    ST_FINISH
  } ctrl_state_t;

endpackage

// ----- design/mexp_modmul.sv -----
// Bit-serial shift-add modular multiplier, one multiplier bit per cycle, MSB first.
module mexp_modmul import mexp_pkg::*; #(
  parameter int MOD_BITS = MOD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DATA_BITS-1:0] a,
  input  logic [MOD_BITS-1:0]  b,
  input  logic [MOD_BITS-1:0]  m,
  output logic                 done,
  output logic [MOD_BITS-1:0]  product
);

  localparam int CNT_BITS = $clog2(DATA_BITS + 1);

  logic [DATA_BITS-1:0] a_sh;
  logic [MOD_BITS-1:0]  b_op;
  logic [CNT_BITS-1:0]  cnt;

  logic [MOD_BITS:0] m_ext;
  logic [MOD_BITS:0] dbl;
  logic [MOD_BITS:0] red1;
  logic [MOD_BITS:0] sum;
  logic [MOD_BITS:0] red2;

  // One step: double the partial product, reduce, add b when the bit is set, reduce.
  // The partial product and b stay below m, so one subtract suffices each time.
  always_comb begin
    m_ext = {1'b0, m};
    dbl   = {product, 1'b0};
    red1  = (dbl >= m_ext) ? (dbl - m_ext) : dbl;
    sum   = {1'b0, red1[MOD_BITS-1:0]} + (a_sh[DATA_BITS-1] ? {1'b0, b_op} : '0);
    red2  = (sum >= m_ext) ? (sum - m_ext) : sum;
  end

  // Bit counter and completion pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= (cnt == CNT_BITS'(1));
      if (start) begin
        cnt <= CNT_BITS'(DATA_BITS);
      end else if (cnt != '0) begin
        cnt <= cnt - CNT_BITS'(1);
      end
    end
  end

  // Operand shift register and accumulator.
  always_ff @(posedge clk) begin
    if (start) begin
      a_sh    <= a;
      b_op    <= b;
      product <= '0;
    end else if (cnt != '0) begin
      a_sh    <= a_sh << 1;
      product <= red2[MOD_BITS-1:0];
    end
  end

endmodule

// ----- design/mexp_cfg.sv -----
// Configuration register file behind the APB-style port: holds the modulus.
module mexp_cfg import mexp_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready,
  output logic [DATA_BITS-1:0]     modulus
);

  reg_idx_t reg_idx;
  logic     wr_en;

  // Word address selects the register; the port never waits.
  always_comb begin
    reg_idx = reg_idx_t'(paddr[APB_ADDR_BITS-1:2]);
    wr_en   = psel && penable && pwrite && (reg_idx == REG_MODULUS);
    pready  = 1'b1;
    prdata  = (reg_idx == REG_MODULUS) ? APB_DATA_BITS'(modulus) : '0;
  end

  // Modulus register.
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= MODULUS_RESET;
    end else if (wr_en) begin
      modulus <= pwdata[DATA_BITS-1:0];
    end
  end

endmodule

// ----- design/mexp_ctrl.sv -----
// Square-and-multiply sequencer with exponent shift register and output register.
module mexp_ctrl import mexp_pkg::*; #(
  parameter int MOD_BITS = MOD_BITS_DEF,
  parameter int EXP_BITS = EXP_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   cmd,
  input  logic [DATA_BITS-1:0]   base,
  input  logic [EXP_IN_BITS-1:0] exponent,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [DATA_BITS-1:0]   result,
  input  logic [MOD_BITS-1:0]    m,
  output logic                   mul_start,
  output logic [DATA_BITS-1:0]   mul_a,
  output logic [MOD_BITS-1:0]    mul_b,
  input  logic                   mul_done,
  input  logic [MOD_BITS-1:0]    mul_product
);

  ctrl_state_t state, state_next;

  logic [EXP_BITS-1:0]  e, e_next;
  logic [MOD_BITS-1:0]  acc, acc_next;
  logic [MOD_BITS-1:0]  b_r, b_r_next;
  logic                 acc_done, acc_done_next;
  logic                 out_valid_next;
  logic [DATA_BITS-1:0] result_next;

  logic                 m_small;
  logic [WIDE_BITS-1:0] e_wide;
  logic [EXP_BITS-1:0]  e_rest;

  // The exponent for an inverse is m - 2; either source is cut to EXP_BITS.
  always_comb begin
    m_small = (m < MOD_BITS'(2));
    e_wide  = cmd ? (WIDE_BITS'(m) - WIDE_BITS'(2)) : WIDE_BITS'(exponent);
    e_rest  = e >> 1;
  end

  // Next state, datapath updates and multiplier requests.
  always_comb begin
    state_next     = state;
    e_next         = e;
    acc_next       = acc;
    b_r_next       = b_r;
    acc_done_next  = acc_done;
    result_next    = result;
    out_valid_next = out_valid && out_stall;
    mul_start      = 1'b0;
    mul_a          = '0;
    mul_b          = '0;
    in_stall       = (state != ST_IDLE);

    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          e_next        = e_wide[EXP_BITS-1:0];
          acc_next      = m_small ? '0 : MOD_BITS'(1);
          acc_done_next = 1'b0;
          if (m_small) begin
            state_next = ST_FINISH;
          end else begin
            // Reduce the base as base * 1 mod m.
            mul_start  = 1'b1;
            mul_a      = base;
            mul_b      = MOD_BITS'(1);
            state_next = ST_REDUCE;
          end
        end
      end
      ST_REDUCE: begin
        if (mul_done) begin
          b_r_next   = mul_product;
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        // Multiply into the accumulator for a set bit, then square unless no bits remain.
        if (e == '0) begin
          state_next = ST_FINISH;
        end else if (e[0] && !acc_done) begin
          mul_start  = 1'b1;
          mul_a      = DATA_BITS'(acc);
          mul_b      = b_r;
          state_next = ST_MUL_ACC;
        end else if (e_rest == '0) begin
          state_next = ST_FINISH;
        end else begin
          mul_start  = 1'b1;
          mul_a      = DATA_BITS'(b_r);
          mul_b      = b_r;
          state_next = ST_MUL_SQ;
        end
      end
      ST_MUL_ACC: begin
        if (mul_done) begin
          acc_next      = mul_product;
          acc_done_next = 1'b1;
          state_next    = ST_DISPATCH;
        end
      end
      ST_MUL_SQ: begin
        if (mul_done) begin
          b_r_next      = mul_product;
          e_next        = e_rest;
          acc_done_next = 1'b0;
          state_next    = ST_DISPATCH;
        end
      end
      ST_FINISH: begin
        // Hand the result to the output register once it is free.
        if (!out_valid || !out_stall) begin
          result_next    = DATA_BITS'(acc);
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register and output beat valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Working registers and output payload.
  always_ff @(posedge clk) begin
    e        <= e_next;
    acc      <= acc_next;
    b_r      <= b_r_next;
    acc_done <= acc_done_next;
    result   <= result_next;
  end

endmodule

// ----- design/modular_exponentiation.sv -----
// Time from accepted beat to result grows with L, the bit length of the effective exponent, and
// with W, its number of set bits; a zero exponent runs only the base reduction, and a modulus
// below two goes straight to the result without any modular product.
// Each modular product runs in the one shared bit-serial multiplier, which sets the rate.
// One item is in work at a time; the next beat is taken the cycle after the result is registered.
// Synchronous active-high reset idles the sequencer, empties the output and sets modulus to 1e9+7.
module modular_exponentiation import mexp_pkg::*; #(
  parameter int MOD_BITS = MOD_BITS_DEF,
  parameter int EXP_BITS = EXP_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     cmd,
  input  logic [DATA_BITS-1:0]     base,
  input  logic [EXP_IN_BITS-1:0]   exponent,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [DATA_BITS-1:0]     result,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready
);

  logic [DATA_BITS-1:0] modulus;
  logic [MOD_BITS-1:0]  m;
  logic                 mul_start;
  logic                 mul_done;
  logic [DATA_BITS-1:0] mul_a;
  logic [MOD_BITS-1:0]  mul_b;
  logic [MOD_BITS-1:0]  mul_product;

  // Only the low MOD_BITS bits of the modulus register take part.
  assign m = modulus[MOD_BITS-1:0];

  // Configuration registers.
  mexp_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .modulus (modulus)
  );

  // Sequencer.
  mexp_ctrl #(
    .MOD_BITS (MOD_BITS),
    .EXP_BITS (EXP_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .base        (base),
    .exponent    (exponent),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .result      (result),
    .m           (m),
    .mul_start   (mul_start),
    .mul_a       (mul_a),
    .mul_b       (mul_b),
    .mul_done    (mul_done),
    .mul_product (mul_product)
  );

  // Shared modular multiplier.
  mexp_modmul #(
    .MOD_BITS (MOD_BITS)
  ) u_modmul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .m       (m),
    .done    (mul_done),
    .product (mul_product)
  );

endmodule

// ----- design/mexp_checker.sv -----
// Port-level checker for the modular exponentiation block, bound to the top level.
module mexp_checker import mexp_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [DATA_BITS-1:0] result,
  input logic                 pready
);

  // A stalled output beat stays and keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(result))
    else $error("output beat changed while stalled");

  // An accepted beat keeps the block busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after an accepted beat");

  // A result only appears as the end of work that held the input off.
  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without work in progress");

  // The configuration port never inserts wait states.
  a_pready_high: assert property (@(posedge clk) disable iff (rst)
    pready)
    else $error("pready dropped");

endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (.*);

// ----- bench/modular_exponentiation_test.sv -----
// Self-checking testbench for the modular exponentiation block.
`timescale 1ns / 100ps

module modular_exponentiation_test;
  import mexp_pkg::*;

  // Command codes carried on the cmd field.
  localparam bit OP_POWER   = 1'b0;
  localparam bit OP_INVERSE = 1'b1;

  // Cycles with no beat at all before the run is declared hung, and the quiet tail at the end.
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int TAIL_CYCLES    = 2200;

  localparam logic [DATA_BITS-1:0] MODULUS_MAX = 31'h7FFF_FFFF;

  // One accepted beat and the result it must produce.
  typedef struct {
    bit                   op;
    bit [DATA_BITS-1:0]   b;
    bit [EXP_IN_BITS-1:0] e;
    bit [DATA_BITS-1:0]   m;
    bit [DATA_BITS-1:0]   r;
  } power_job_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     cmd = 1'b0;
  logic [DATA_BITS-1:0]     base = '0;
  logic [EXP_IN_BITS-1:0]   exponent = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [DATA_BITS-1:0]     result;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [APB_ADDR_BITS-1:0] paddr = '0;
  logic [APB_DATA_BITS-1:0] pwdata = '0;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;

  // Bench copy of the modulus register and the queue of pending powers.
  bit [DATA_BITS-1:0] modulus_cfg = MODULUS_RESET;
  power_job_t         pending_powers[$];

  int unsigned sender_idle_pct    = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned items_sent         = 0;
  int unsigned results_seen       = 0;
  int unsigned idle_cycles        = 0;
  int unsigned errors             = 0;

  modular_exponentiation dut (.*);

  // Free-running 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Right-to-left square-and-multiply over all 32 exponent bits.
  function automatic bit [DATA_BITS-1:0] predict_power(input bit op, input bit [DATA_BITS-1:0] b,
                                                       input bit [EXP_IN_BITS-1:0] e,
                                                       input bit [DATA_BITS-1:0] m);
    bit [63:0] mm;
    bit [63:0] ex;
    bit [63:0] acc;
    bit [63:0] sq;
    mm = m;
    if (mm < 2) return '0;
    ex = (op == OP_INVERSE) ? mm - 2 : 64'(e);
    acc = 1;
    sq = b % mm;
    for (int i = 0; i < EXP_IN_BITS; i++) begin
      if (ex[i]) acc = (acc * sq) % mm;
      sq = (sq * sq) % mm;
    end
    return acc[DATA_BITS-1:0];
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    errors++;
  endtask

  // Offer one beat after a random idle gap and hold it until it is taken.
  task automatic send_item(input bit op, input bit [DATA_BITS-1:0] b,
                           input bit [EXP_IN_BITS-1:0] e);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= op;
    base     <= b;
    exponent <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Stop offering beats and wait until every outstanding result has come back.
  task automatic wait_results_done();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_seen < items_sent);
  endtask

  // Write the modulus through the configuration port once the block has gone idle.
  task automatic write_modulus(input bit [APB_DATA_BITS-1:0] value);
    wait_results_done();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_MODULUS, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    modulus_cfg = value[DATA_BITS-1:0];
  endtask

  // Field extremes and the zero cases at the modulus left by reset.
  task automatic test_reset_modulus();
    send_item(OP_POWER, '0, '0);
    send_item(OP_POWER, MODULUS_MAX, '0);
    send_item(OP_POWER, MODULUS_MAX, '1);
    send_item(OP_POWER, 31'd2, 32'd10);
    send_item(OP_INVERSE, 31'd2, 32'd0);
    send_item(OP_INVERSE, '0, 32'h1234_5678);
    send_item(OP_POWER, MODULUS_RESET, 32'd5);
    send_item(OP_POWER, '0, '1);
    send_item(OP_INVERSE, MODULUS_MAX, '1);
  endtask

  // Smallest and largest legal modulus, moduli below two and a composite modulus.
  task automatic test_modulus_extremes();
    // Bit 31 of the write data is not part of the register.
    write_modulus(32'h8000_0002);
    send_item(OP_INVERSE, '0, 32'd7);
    send_item(OP_INVERSE, 31'd1, '1);
    send_item(OP_POWER, 31'd3, 32'd5);

    write_modulus(32'(MODULUS_MAX));
    send_item(OP_INVERSE, MODULUS_MAX, 32'd0);
    send_item(OP_INVERSE, 31'd12345, 32'd0);
    send_item(OP_POWER, MODULUS_MAX - 1, '1);

    write_modulus(32'd1);
    send_item(OP_POWER, 31'd5, 32'd3);
    send_item(OP_POWER, '0, '0);

    write_modulus(32'd0);
    send_item(OP_INVERSE, 31'd7, 32'd0);

    write_modulus(32'd15);
    send_item(OP_INVERSE, 31'd7, 32'd0);
    send_item(OP_POWER, 31'd16, 32'd2);
  endtask

  // Random beats under one idling pattern and one modulus.
  task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct,
                                     input bit [APB_DATA_BITS-1:0] modulus_value,
                                     input int unsigned count);
    bit                   op;
    bit [DATA_BITS-1:0]   b;
    bit [EXP_IN_BITS-1:0] e;
    write_modulus(modulus_value);
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    for (int n = 0; n < count; n++) begin
      // Now and then let the block drain completely before the next beat.
      if ($urandom_range(24) == 0) wait_results_done();
      op = ($urandom_range(3) == 0) ? OP_INVERSE : OP_POWER;
      case ($urandom_range(3))
        0: b = ($urandom_range(1) == 0) ? '0 : MODULUS_MAX;
        1: b = DATA_BITS'($urandom_range(1000));
        default: b = DATA_BITS'($urandom);
      endcase
      // Short exponents keep many items fast; full-width ones still appear often.
      case ($urandom_range(4))
        0: e = ($urandom_range(1) == 0) ? '0 : '1;
        1, 2: e = $urandom >> $urandom_range(32);
        default: e = $urandom;
      endcase
      send_item(op, b, e);
    end
  endtask

  // The receiver stalls at random according to the current pattern.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < receiver_stall_pct);
  end

  // Predict on every accepted input beat and check every accepted result beat.
  always @(posedge clk) begin
    power_job_t job;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        job.op = cmd;
        job.b  = base;
        job.e  = exponent;
        job.m  = modulus_cfg;
        job.r  = predict_power(cmd, base, exponent, modulus_cfg);
        pending_powers = {pending_powers, job};
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (pending_powers.size() == 0) begin
          report_mismatch($sformatf("result %0d with nothing expected", result));
        end else begin
          job = pending_powers.pop_front();
          if (result !== job.r)
            report_mismatch($sformatf("cmd %0d base %0d exp %0d mod %0d: result %0d, want %0d",
                                      job.op, job.b, job.e, job.m, result, job.r));
        end
      end
    end
  end

  // Watchdog on cycles in which no beat moves on any port.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Test sequence.
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_reset_modulus();
    test_modulus_extremes();
    test_random_traffic(0, 0, 32'(MODULUS_RESET), 67);
    test_random_traffic(67, 0, 32'(MODULUS_MAX), 67);
    test_random_traffic(0, 67, $urandom_range(32'h7FFF_FFFF, 2), 67);
    test_random_traffic(20, 20, $urandom_range(255, 2), 67);

    wait_results_done();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_powers.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_powers.size()));

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
